>>> src/assert_macros.svh
// Assertion macros used by the dispatcher controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> src/ptd_pkg.sv
// Types and constants of the periodic task dispatcher.
package ptd_pkg;
	localparam logic [2:0] OP_SCHEDULE = 3'd0;
	localparam logic [2:0] OP_TICK     = 3'd1;
	localparam logic [2:0] OP_POLL     = 3'd2;
	localparam logic [2:0] OP_DONE     = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_BAD_PER   = 3'd2;
	localparam logic [2:0] ST_BAD_OFF   = 3'd3;
	localparam logic [2:0] ST_BAD_PRIO  = 3'd4;
	localparam logic [2:0] ST_BAD_MODE  = 3'd5;
	localparam logic [2:0] ST_BAD_INDEX = 3'd6;

	localparam logic [1:0] RS_IDLE    = 2'd0;
	localparam logic [1:0] RS_READY   = 2'd1;
	localparam logic [1:0] RS_RUNNING = 2'd2;

	localparam logic [1:0] CFG_MODE    = 2'd0;
	localparam logic [1:0] CFG_OVR_LIM = 2'd1;
	localparam logic [1:0] CFG_MIS_LIM = 2'd2;

	localparam logic signed [7:0] LOWEST_PRIO = -8'sd127;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_WRITE = 6'b001000,
		S_FIND  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic shift_step;
		logic insert;
		logic find_start;
		logic find_step;
		logic dispatch;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic shift_last;
		logic find_last;
		logic found;
		logic pre_done;
		logic do_find;
	} ctl_sts_t;
endpackage

>>> src/ptd_ctrl.sv
// Controller state machine of the periodic task dispatcher.
`include "assert_macros.svh"
module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ptd_pkg::ctl_cmd_t cmd,
	input  ptd_pkg::ctl_sts_t sts
);
	import ptd_pkg::*;
	state_t state_q;
	state_t state_d;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_start = 1'b1;
				if (sts.pre_done) begin
					state_d = sts.do_find ? S_FIND : S_OUT;
					cmd.find_start = sts.do_find;
					cmd.finish = !sts.do_find;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.insert = 1'b1;
				cmd.find_start = sts.do_find;
				cmd.finish = !sts.do_find;
				state_d = sts.do_find ? S_FIND : S_OUT;
			end
			S_FIND: begin
				cmd.find_step = 1'b1;
				if (sts.found) begin
					cmd.dispatch = 1'b1;
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end else if (sts.find_last) begin
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
	`ASSERT_CLK(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`ASSERT_CLK(a_accept, clk, arst_n, (state_q == S_IDLE && in_valid) |=> state_q == S_SCAN,
		"accepted item not started")
	`ASSERT_CLK(a_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid,
		"result dropped while stalled")
endmodule

>>> src/ptd_dpath.sv
// Task table, walk counters and result register of the dispatcher.
module ptd_dpath #(
	parameter int MAX_TASKS = 8,
	parameter int TICK_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptd_pkg::ctl_cmd_t   cmd,
	output ptd_pkg::ctl_sts_t   sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [2:0]          op,
	input  logic [15:0]         period_ticks,
	input  logic [15:0]         offset_ticks,
	input  logic signed [7:0]   priority_req,
	input  logic [3:0]          slot_index,
	output logic [2:0]          status,
	output logic                dispatch_valid,
	output logic [3:0]          dispatch_index,
	output logic [4:0]          tasks_held,
	output logic [1:0]          task_state,
	output logic [7:0]          task_overruns,
	output logic [7:0]          task_misses,
	output logic [15:0]         task_countdown
);
	import ptd_pkg::*;
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int PW = (TICK_BITS > 16) ? TICK_BITS : 16;

	logic signed [7:0] prio_q [MAX_TASKS];
	logic [TICK_BITS-1:0] per_q [MAX_TASKS];
	logic [TICK_BITS-1:0] cnt_q [MAX_TASKS];
	logic [1:0] rs_q [MAX_TASKS];
	logic [7:0] ovr_q [MAX_TASKS];
	logic [7:0] mis_q [MAX_TASKS];
	logic [CW-1:0] count_q;
	logic signed [7:0] run_prio_q;
	logic mode_q;
	logic [7:0] ovr_lim_q, mis_lim_q;

	logic [2:0] op_q;
	logic [15:0] per_in_q, off_in_q;
	logic signed [7:0] prio_in_q;
	logic [3:0] idx_in_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] find_q;
	logic use_floor_q;

	logic [2:0] sched_st;
	logic idx_ok;
	logic [IW-1:0] wi, fi, ii;
	logic walk_end;
	logic is_shift;
	logic [TICK_BITS-1:0] cnt_dec;
	logic [CW-1:0] ins_pos;

	assign idx_ok = ({1'b0, idx_in_q} < 5'(count_q));
	assign ii = idx_in_q[IW-1:0];
	assign wi = walk_q[IW-1:0];
	assign fi = find_q[IW-1:0];
	assign is_shift = (op_q == OP_SCHEDULE);
	assign walk_end = is_shift ? (walk_q <= pos_q) : (walk_q >= count_q);

	always_comb begin
		if (32'(count_q) >= MAX_TASKS) begin
			sched_st = ST_FULL;
		end else if (per_in_q == '0 || PW'(per_in_q) > PW'({TICK_BITS{1'b1}})) begin
			sched_st = ST_BAD_PER;
		end else if (PW'(off_in_q) > PW'({TICK_BITS{1'b1}})) begin
			sched_st = ST_BAD_OFF;
		end else if (prio_in_q <= LOWEST_PRIO) begin
			sched_st = ST_BAD_PRIO;
		end else begin
			sched_st = ST_OK;
		end
	end

	always_comb begin
		sts = '0;
		sts.shift_last = walk_end;
		sts.find_last = (find_q >= count_q);
		sts.found = (find_q < count_q) && rs_q[fi] == RS_READY &&
			(!use_floor_q || prio_q[fi] > run_prio_q);
		case (op_q)
			OP_SCHEDULE: sts.pre_done = (sched_st != ST_OK);
			OP_TICK:     sts.pre_done = (count_q == '0);
			default:     sts.pre_done = 1'b1;
		endcase
		case (op_q)
			OP_SCHEDULE: sts.do_find = 1'b0;
			OP_TICK:     sts.do_find = !mode_q;
			OP_POLL:     sts.do_find = mode_q;
			OP_DONE:     sts.do_find = !mode_q && idx_ok;
			default:     sts.do_find = 1'b0;
		endcase
	end

	assign cnt_dec = (cnt_q[wi] != '0) ? cnt_q[wi] - 1'b1 : cnt_q[wi];

	always_comb begin
		ins_pos = count_q;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (CW'(i) < count_q && (prio_q[i] < prio_in_q ||
				(prio_q[i] == prio_in_q && TICK_BITS'(per_in_q) < per_q[i]))) begin
				ins_pos = CW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			per_in_q <= period_ticks;
			off_in_q <= offset_ticks;
			prio_in_q <= priority_req;
			idx_in_q <= slot_index;
			walk_q <= '0;
		end else if (cmd.scan_start && is_shift) begin
			walk_q <= count_q;
		end else if (cmd.shift_step && !walk_end) begin
			walk_q <= is_shift ? walk_q - 1'b1 : walk_q + 1'b1;
		end
		if (cmd.scan_start) begin
			pos_q <= ins_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_step && !walk_end) begin
			if (is_shift) begin
				prio_q[wi] <= prio_q[IW'(walk_q - 1'b1)];
				per_q[wi]  <= per_q[IW'(walk_q - 1'b1)];
				cnt_q[wi]  <= cnt_q[IW'(walk_q - 1'b1)];
				rs_q[wi]   <= rs_q[IW'(walk_q - 1'b1)];
				ovr_q[wi]  <= ovr_q[IW'(walk_q - 1'b1)];
				mis_q[wi]  <= mis_q[IW'(walk_q - 1'b1)];
			end else if (op_q == OP_TICK) begin
				if (cnt_dec == '0) begin
					cnt_q[wi] <= per_q[wi];
					if (rs_q[wi] == RS_IDLE) begin
						rs_q[wi] <= RS_READY;
					end else if (rs_q[wi] == RS_RUNNING) begin
						ovr_q[wi] <= (9'(ovr_q[wi]) + 9'd1 < 9'(ovr_lim_q)) ?
							ovr_q[wi] + 8'd1 : ovr_lim_q;
					end else begin
						mis_q[wi] <= (9'(mis_q[wi]) + 9'd1 < 9'(mis_lim_q)) ?
							mis_q[wi] + 8'd1 : mis_lim_q;
					end
				end else begin
					cnt_q[wi] <= cnt_dec;
				end
			end
		end
		if (cmd.insert && is_shift) begin
			prio_q[IW'(pos_q)] <= prio_in_q;
			per_q[IW'(pos_q)]  <= TICK_BITS'(per_in_q);
			cnt_q[IW'(pos_q)]  <= TICK_BITS'(off_in_q);
			rs_q[IW'(pos_q)]   <= RS_IDLE;
			ovr_q[IW'(pos_q)]  <= '0;
			mis_q[IW'(pos_q)]  <= '0;
		end
		if (cmd.scan_start && sts.pre_done && op_q == OP_DONE && idx_ok) begin
			rs_q[ii] <= RS_IDLE;
		end
		if (cmd.dispatch) begin
			rs_q[fi] <= RS_RUNNING;
		end
		if (cmd.find_start) begin
			find_q <= (op_q == OP_DONE) ? CW'(idx_in_q) + 1'b1 : '0;
		end else if (cmd.find_step && !sts.found && !sts.find_last) begin
			find_q <= find_q + 1'b1;
		end
		if (cmd.finish) begin
			case (op_q)
				OP_SCHEDULE: status <= sched_st;
				OP_POLL:     status <= mode_q ? ST_OK : ST_BAD_MODE;
				OP_DONE:     status <= idx_ok ? ST_OK : ST_BAD_INDEX;
				OP_READ:     status <= idx_ok ? ST_OK : ST_BAD_INDEX;
				default:     status <= ST_OK;
			endcase
			dispatch_valid <= cmd.dispatch;
			dispatch_index <= cmd.dispatch ? 4'(find_q) : 4'd0;
			if (op_q == OP_READ && idx_ok) begin
				task_state <= rs_q[ii];
				task_overruns <= ovr_q[ii];
				task_misses <= mis_q[ii];
				task_countdown <= 16'(cnt_q[ii]);
			end else begin
				task_state <= '0;
				task_overruns <= '0;
				task_misses <= '0;
				task_countdown <= '0;
			end
			tasks_held <= 5'(count_q) + ((is_shift && sched_st == ST_OK) ? 5'd1 : 5'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			run_prio_q <= LOWEST_PRIO;
			mode_q <= 1'b0;
			ovr_lim_q <= 8'd255;
			mis_lim_q <= 8'd255;
			use_floor_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:    mode_q <= cfg_data[0];
					CFG_OVR_LIM: ovr_lim_q <= cfg_data;
					CFG_MIS_LIM: mis_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.finish && is_shift && sched_st == ST_OK) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.find_start) begin
				use_floor_q <= !mode_q;
				if (op_q == OP_DONE) begin
					run_prio_q <= LOWEST_PRIO;
				end
			end
			if (cmd.dispatch && use_floor_q) begin
				run_prio_q <= prio_q[fi];
			end
		end
	end
endmodule

>>> src/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher.
//  channel  | handshake           | payload
//  input    | in_valid/in_stall   | op, period_ticks, offset_ticks, priority_req, slot_index
//  result   | out_valid/out_stall | status, dispatch_*, tasks_held, task_*
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
// Every item passes SCAN and OUT. Tick on a non-empty table and accepted schedule then walk
// the table in SHIFT, one entry per cycle, and pass WRITE. A dispatch search steps through
// the entries in FIND until one is found or the table ends.
// Reset clears the task count and mode, sets the running priority to LOWEST_PRIO and
// sets both limits to 255.
// Input stalls from acceptance until the result transfers; the result holds under stall.
module periodic_task_dispatcher #(
	parameter int MAX_TASKS = 8,
	parameter int TICK_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        op,
	input  logic [15:0]       period_ticks,
	input  logic [15:0]       offset_ticks,
	input  logic signed [7:0] priority_req,
	input  logic [3:0]        slot_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic              dispatch_valid,
	output logic [3:0]        dispatch_index,
	output logic [4:0]        tasks_held,
	output logic [1:0]        task_state,
	output logic [7:0]        task_overruns,
	output logic [7:0]        task_misses,
	output logic [15:0]       task_countdown,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import ptd_pkg::*;
	ctl_cmd_t cmd;
	ctl_sts_t sts;
	assign cfg_ready = 1'b1;
	ptd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);
	ptd_dpath #(.MAX_TASKS(MAX_TASKS), .TICK_BITS(TICK_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .period_ticks(period_ticks), .offset_ticks(offset_ticks),
		.priority_req(priority_req), .slot_index(slot_index),
		.status(status), .dispatch_valid(dispatch_valid), .dispatch_index(dispatch_index),
		.tasks_held(tasks_held), .task_state(task_state), .task_overruns(task_overruns),
		.task_misses(task_misses), .task_countdown(task_countdown)
	);
endmodule

>>> bench/tb_periodic_task_dispatcher.sv
// Self-checking testbench of the periodic task dispatcher: queued stimulus, predicted results.
`timescale 1ns / 1ps
module tb_periodic_task_dispatcher;
	import ptd_pkg::*;

	localparam int NTASK = 8;
	localparam int LIMIT_CYCLES = 600000;

	typedef struct packed {
		logic [2:0]        op;
		logic [15:0]       period;
		logic [15:0]       offset;
		logic signed [7:0] prio;
		logic [3:0]        idx;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        dv;
		logic [3:0]  di;
		logic [4:0]  held;
		logic [1:0]  tstate;
		logic [7:0]  ovr;
		logic [7:0]  mis;
		logic [15:0] cnt;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic [2:0] op = '0;
	logic [15:0] period_ticks = '0, offset_ticks = '0;
	logic signed [7:0] priority_req = '0;
	logic [3:0] slot_index = '0;
	logic out_valid, out_stall = 1'b0;
	logic [2:0] status;
	logic dispatch_valid;
	logic [3:0] dispatch_index;
	logic [4:0] tasks_held;
	logic [1:0] task_state;
	logic [7:0] task_overruns, task_misses;
	logic [15:0] task_countdown;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	periodic_task_dispatcher DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [7:0] t_prio [NTASK];
	logic [15:0] t_per [NTASK], t_cnt [NTASK];
	logic [1:0] t_rs [NTASK];
	logic [7:0] t_ovr [NTASK], t_mis [NTASK];
	int unsigned n_tasks = 0;
	logic signed [7:0] run_prio = LOWEST_PRIO;
	logic m_mode = 1'b0;
	logic [7:0] m_ovr_lim = 8'd255, m_mis_lim = 8'd255;

	cmd_t pending_cmds [$];
	resp_t expected_resps [$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;

	function automatic logic [7:0] sat_up(logic [7:0] v, logic [7:0] lim);
		int n;
		n = v + 1;
		return (n < lim) ? n[7:0] : lim;
	endfunction

	function automatic int first_ready(int start, bit use_floor, logic signed [7:0] floor);
		for (int i = start; i < n_tasks; i++)
			if (t_rs[i] == RS_READY && (!use_floor || t_prio[i] > floor)) return i;
		return -1;
	endfunction

	task automatic run_dispatch(int i, bit set_prio, inout resp_t r);
		if (i >= 0) begin
			t_rs[i] = RS_RUNNING;
			if (set_prio) run_prio = t_prio[i];
			r.dv = 1'b1;
			r.di = i[3:0];
		end
	endtask

	task automatic predict_dispatch(cmd_t c);
		resp_t r;
		int pos;
		r = '0;
		case (c.op)
			OP_SCHEDULE: begin
				if (n_tasks >= NTASK) r.status = ST_FULL;
				else if (c.period == 0) r.status = ST_BAD_PER;
				else if (c.prio <= LOWEST_PRIO) r.status = ST_BAD_PRIO;
				else begin
					pos = n_tasks;
					for (int i = 0; i < n_tasks; i++)
						if (t_prio[i] < c.prio || (t_prio[i] == c.prio && c.period < t_per[i])) begin
							pos = i;
							break;
						end
					for (int i = n_tasks; i > pos; i--) begin
						t_prio[i] = t_prio[i-1]; t_per[i] = t_per[i-1]; t_cnt[i] = t_cnt[i-1];
						t_rs[i] = t_rs[i-1]; t_ovr[i] = t_ovr[i-1]; t_mis[i] = t_mis[i-1];
					end
					t_prio[pos] = c.prio; t_per[pos] = c.period; t_cnt[pos] = c.offset;
					t_rs[pos] = RS_IDLE; t_ovr[pos] = 0; t_mis[pos] = 0;
					n_tasks++;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < n_tasks; i++) begin
					if (t_cnt[i] != 0) t_cnt[i]--;
					if (t_cnt[i] == 0) begin
						if (t_rs[i] == RS_IDLE) t_rs[i] = RS_READY;
						else if (t_rs[i] == RS_RUNNING) t_ovr[i] = sat_up(t_ovr[i], m_ovr_lim);
						else t_mis[i] = sat_up(t_mis[i], m_mis_lim);
						t_cnt[i] = t_per[i];
					end
				end
				if (!m_mode) run_dispatch(first_ready(0, 1, run_prio), 1, r);
			end
			OP_POLL: begin
				if (!m_mode) r.status = ST_BAD_MODE;
				else run_dispatch(first_ready(0, 0, 0), 0, r);
			end
			OP_DONE: begin
				if (c.idx >= n_tasks) r.status = ST_BAD_INDEX;
				else begin
					t_rs[c.idx] = RS_IDLE;
					if (!m_mode) begin
						run_prio = LOWEST_PRIO;
						run_dispatch(first_ready(c.idx + 1, 1, run_prio), 1, r);
					end
				end
			end
			OP_READ: begin
				if (c.idx >= n_tasks) r.status = ST_BAD_INDEX;
				else begin
					r.tstate = t_rs[c.idx]; r.ovr = t_ovr[c.idx];
					r.mis = t_mis[c.idx]; r.cnt = t_cnt[c.idx];
				end
			end
			default: ;
		endcase
		r.held = n_tasks[4:0];
		expected_resps.push_back(r);
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_dispatch({op, period_ticks, offset_ticks, priority_req, slot_index});
				in_gap = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) in_gap = 0;
			end
			if (in_valid && in_stall) begin
			end else if (in_gap > 0 || pending_cmds.size() == 0) begin
				if (in_gap > 0) in_gap--;
				in_valid <= 1'b0;
			end else begin
				cmd_t c;
				c = pending_cmds.pop_front();
				in_valid <= 1'b1;
				op <= c.op; period_ticks <= c.period; offset_ticks <= c.offset;
				priority_req <= c.prio; slot_index <= c.idx;
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				resp_t got, exp_r;
				got = {status, dispatch_valid, dispatch_index, tasks_held, task_state,
					task_overruns, task_misses, task_countdown};
				if (expected_resps.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					errors++;
				end else begin
					exp_r = expected_resps.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected st=%0d dv=%0d di=%0d n=%0d ts=%0d o=%0d m=%0d c=%0d",
							$time, exp_r.status, exp_r.dv, exp_r.di, exp_r.held, exp_r.tstate,
							exp_r.ovr, exp_r.mis, exp_r.cnt);
						$display("%0t:          actual   st=%0d dv=%0d di=%0d n=%0d ts=%0d o=%0d m=%0d c=%0d",
							$time, got.status, got.dv, got.di, got.held, got.tstate,
							got.ovr, got.mis, got.cnt);
						errors++;
					end
				end
				out_gap = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) out_gap = 0;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	task automatic put_cmd(logic [2:0] o, logic [15:0] p, logic [15:0] f,
		logic signed [7:0] pr, logic [3:0] i);
		pending_cmds.push_back({o, p, f, pr, i});
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_resps.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] ri, logic [7:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= ri; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (ri)
			CFG_MODE:    m_mode = d[0];
			CFG_OVR_LIM: m_ovr_lim = d;
			CFG_MIS_LIM: m_mis_lim = d;
			default: ;
		endcase
	endtask

	task automatic rand_items(int count, bit busy);
		logic [2:0] o;
		logic [15:0] p, f;
		logic signed [7:0] pr;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0, 1: o = OP_SCHEDULE;
				2, 3, 4: o = OP_TICK;
				5: o = OP_POLL;
				6: o = OP_DONE;
				7, 8: o = OP_READ;
				default: o = 3'($urandom_range(0, 7));
			endcase
			if (busy && o == OP_SCHEDULE && $urandom_range(0, 2) == 0) o = OP_DONE;
			p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
			f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
			pr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
			put_cmd(o, p, f, pr, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		put_cmd(OP_READ, 0, 0, 0, 0);
		put_cmd(OP_DONE, 0, 0, 0, 15);
		put_cmd(OP_POLL, 0, 0, 0, 0);
		put_cmd(OP_SCHEDULE, 0, 3, 5, 0);
		put_cmd(OP_SCHEDULE, 4, 0, -8'sd127, 0);
		put_cmd(OP_SCHEDULE, 4, 0, -8'sd128, 0);
		put_cmd(OP_SCHEDULE, 16'hFFFF, 16'hFFFF, 8'sd127, 0);
		put_cmd(OP_SCHEDULE, 2, 1, -8'sd126, 0);
		put_cmd(OP_SCHEDULE, 3, 1, 8'sd10, 0);
		put_cmd(OP_SCHEDULE, 1, 1, 8'sd10, 0);
		put_cmd(OP_SCHEDULE, 1, 2, 8'sd10, 0);
		put_cmd(OP_SCHEDULE, 2, 0, 8'sd10, 0);
		put_cmd(OP_SCHEDULE, 5, 1, 8'sd0, 0);
		put_cmd(OP_SCHEDULE, 1, 0, 8'sd3, 0);
		put_cmd(OP_SCHEDULE, 1, 0, 8'sd3, 0);
		for (int i = 0; i < 4; i++) put_cmd(OP_TICK, 0, 0, 0, 0);
		put_cmd(OP_DONE, 0, 0, 0, 1);
		put_cmd(OP_READ, 0, 0, 0, 7);
		put_cmd(OP_READ, 0, 0, 0, 8);
		put_cmd(3'd5, 16'hFFFF, 16'hFFFF, -1, 15);
		put_cmd(3'd7, 0, 0, 0, 0);
		wait_idle();
		write_reg(CFG_OVR_LIM, 8'd2);
		write_reg(CFG_MIS_LIM, 8'd0);
		for (int i = 0; i < 10; i++) put_cmd(OP_TICK, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++) put_cmd(OP_READ, 0, 0, 0, 4'(i));
		// receiver holds off while items keep coming
		hold_off = 300;
		rand_items(150, 1);
		wait_idle();
		write_reg(CFG_MODE, 8'd1);
		write_reg(CFG_OVR_LIM, 8'd255);
		write_reg(CFG_MIS_LIM, 8'd255);
		rand_items(250, 1);
		wait_idle();
		write_reg(CFG_MODE, 8'd0);
		write_reg(CFG_OVR_LIM, 8'($urandom));
		write_reg(CFG_MIS_LIM, 8'($urandom));
		rand_items(250, 1);
		wait_idle();
		write_reg(CFG_MODE, 8'd1);
		write_reg(CFG_OVR_LIM, 8'd0);
		write_reg(CFG_MIS_LIM, 8'd1);
		rand_items(200, 1);
		wait_idle();
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
